>>> rtl/aesu_pkg.sv
package aesu_pkg;

  // counter limits
  localparam int unsigned MaxAlignLen = 65536;
  localparam int unsigned CntCap      = (MaxAlignLen < 131071) ? MaxAlignLen : 131071;
  localparam int unsigned CntW        = 17;

  typedef logic [CntW-1:0] cnt_t;

  localparam cnt_t CntCapV = cnt_t'(CntCap);

  // run kinds, also the op_kind codes on the result port
  typedef enum logic [1:0] {
    KindSub = 2'd0,
    KindDel = 2'd1,
    KindIns = 2'd2
  } kind_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegMatchReward    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMismatchPenalty = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGapOpenCost    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGapExtendCost  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGapSymbol      = 3'd4;

  typedef struct packed {
    logic [7:0] match_reward;
    logic [7:0] mismatch_penalty;
    logic [7:0] gap_open_cost;
    logic [7:0] gap_extend_cost;
    logic [7:0] gap_symbol;
  } cfg_t;

  // classified column handed from front to back
  typedef struct packed {
    kind_e kind;
    logic  is_match;
    logic  last;
  } col_t;

  // one result word
  typedef struct packed {
    kind_e              kind;
    cnt_t               run_length;
    logic               is_final;
    logic signed [31:0] score;
    cnt_t               ident;
    cnt_t               opens;
    cnt_t               gap_cols;
    cnt_t               ops;
    cnt_t               cols;
  } res_t;

  // result writes from back to output queue
  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } res_push_t;

  // queue sizes
  localparam int unsigned MidDepth = 4;
  localparam int unsigned MidPtrW  = $clog2(MidDepth);
  localparam int unsigned MidCntW  = $clog2(MidDepth + 1);
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v >= CntCapV) ? CntCapV : v + cnt_t'(1);
  endfunction

endpackage

>>> rtl/aesu_front.sv
module aesu_front import aesu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] query_char_i,
  input  logic [7:0] subject_char_i,
  input  logic       end_of_alignment_i,
  input  logic [7:0] gap_symbol_i,
  output logic       full_o,
  output logic       col_valid_o,
  output col_t       col_o,
  input  logic       col_pop_i
);

  logic               open_q, open_d;
  kind_e              kind_q, kind_d;
  col_t               mem_q [MidDepth];
  logic [MidPtrW-1:0] wp_q, rp_q;
  logic [MidCntW-1:0] cnt_q, cnt_d;
  logic               qg, sg, accept;
  kind_e              kind;
  col_t               col_in;

  assign qg = (query_char_i == gap_symbol_i);
  assign sg = (subject_char_i == gap_symbol_i);

  // both-gap column rides on an open gap run, else it is a deletion
  always_comb begin
    priority if (!qg && !sg) begin
      kind = KindSub;
    end else if (qg && sg) begin
      kind = (open_q && kind_q != KindSub) ? kind_q : KindDel;
    end else if (qg) begin
      kind = KindDel;
    end else begin
      kind = KindIns;
    end
  end

  assign full_o = (cnt_q == MidCntW'(MidDepth));
  assign accept = push_i && !full_o;

  assign col_in.kind     = kind;
  assign col_in.is_match = (query_char_i == subject_char_i);
  assign col_in.last     = end_of_alignment_i;

  assign open_d = accept ? !end_of_alignment_i : open_q;
  assign kind_d = accept ? kind : kind_q;

  assign cnt_d = cnt_q + MidCntW'(accept) - MidCntW'(col_pop_i);

  assign col_valid_o = (cnt_q != '0);
  assign col_o       = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      kind_q <= KindSub;
      wp_q   <= '0;
      rp_q   <= '0;
      cnt_q  <= '0;
    end else begin
      open_q <= open_d;
      kind_q <= kind_d;
      cnt_q  <= cnt_d;
      if (accept) begin
        wp_q <= wp_q + MidPtrW'(1);
      end
      if (col_pop_i) begin
        rp_q <= rp_q + MidPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wp_q] <= col_in;
    end
  end

  a_mid_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MidCntW'(MidDepth))
    else $error("column queue overflow");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_pop_i |-> col_valid_o)
    else $error("column popped from empty queue");

endmodule

>>> rtl/aesu_back.sv
module aesu_back import aesu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      col_valid_i,
  input  col_t      col_i,
  input  logic      room_i,
  output logic      col_pop_o,
  output res_push_t push_o,
  output res_t      res_a_o,
  output res_t      res_b_o
);

  kind_e              run_kind_q;
  logic               run_open_q;
  cnt_t               run_count_q, ident_q, opens_q, gap_cols_q, ops_q, cols_q;
  logic signed [31:0] score_q;

  logic               go, close_prev, start, is_gap, charge_a, charge_b;
  cnt_t               run_count_n, ident_n, opens_n, gap_cols_n, ops_n, cols_n;
  cnt_t               mul_cnt;
  logic        [24:0] ext_cost;
  logic        [25:0] gap_cost, cost_b;
  logic        [33:0] sum_a, delta_b, sum_b;
  logic signed [31:0] score_a, score_n;

  function automatic logic signed [31:0] clamp32(input logic [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  assign go        = col_valid_i && room_i;
  assign col_pop_o = go;

  assign is_gap     = (col_i.kind != KindSub);
  assign close_prev = run_open_q && (col_i.kind != run_kind_q);
  assign start      = close_prev || !run_open_q;

  assign run_count_n = start ? cnt_t'(1) : sat_inc(run_count_q);
  assign ops_n       = start ? sat_inc(ops_q) : ops_q;
  assign opens_n     = (start && is_gap) ? sat_inc(opens_q) : opens_q;
  assign gap_cols_n  = is_gap ? sat_inc(gap_cols_q) : gap_cols_q;
  assign cols_n      = sat_inc(cols_q);
  assign ident_n     = (!is_gap && col_i.is_match) ? sat_inc(ident_q) : ident_q;

  // gap run cost charged when the run closes, with the registers of that moment
  assign charge_a = close_prev && (run_kind_q != KindSub);
  assign charge_b = col_i.last && is_gap;

  // one multiplier: the closing previous run, else the run holding this column
  assign mul_cnt  = close_prev ? run_count_q : run_count_n;
  assign ext_cost = 25'(cfg_i.gap_extend_cost) * 25'(mul_cnt);
  assign gap_cost = 26'(ext_cost) + 26'(cfg_i.gap_open_cost);
  // a run opened by this column has length one
  assign cost_b   = close_prev ? (26'(cfg_i.gap_open_cost) + 26'(cfg_i.gap_extend_cost))
                               : gap_cost;

  assign sum_a   = {{2{score_q[31]}}, score_q} - {8'd0, gap_cost};
  assign score_a = charge_a ? clamp32(sum_a) : score_q;

  always_comb begin
    priority if (!is_gap && col_i.is_match) begin
      delta_b = {26'd0, cfg_i.match_reward};
    end else if (!is_gap) begin
      delta_b = 34'd0 - {26'd0, cfg_i.mismatch_penalty};
    end else if (charge_b) begin
      delta_b = 34'd0 - {8'd0, cost_b};
    end else begin
      delta_b = '0;
    end
  end

  assign sum_b   = {{2{score_a[31]}}, score_a} + delta_b;
  assign score_n = clamp32(sum_b);

  assign push_o.a_valid = go && close_prev;
  assign push_o.b_valid = go && col_i.last;

  // previous run closing: totals before this column
  assign res_a_o.kind       = run_kind_q;
  assign res_a_o.run_length = run_count_q;
  assign res_a_o.is_final   = 1'b0;
  assign res_a_o.score      = score_a;
  assign res_a_o.ident      = ident_q;
  assign res_a_o.opens      = opens_q;
  assign res_a_o.gap_cols   = gap_cols_q;
  assign res_a_o.ops        = ops_q;
  assign res_a_o.cols       = cols_q;

  // final run closing: totals including this column
  assign res_b_o.kind       = col_i.kind;
  assign res_b_o.run_length = run_count_n;
  assign res_b_o.is_final   = 1'b1;
  assign res_b_o.score      = score_n;
  assign res_b_o.ident      = ident_n;
  assign res_b_o.opens      = opens_n;
  assign res_b_o.gap_cols   = gap_cols_n;
  assign res_b_o.ops        = ops_n;
  assign res_b_o.cols       = cols_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_kind_q  <= KindSub;
      run_open_q  <= 1'b0;
      run_count_q <= '0;
      score_q     <= '0;
      ident_q     <= '0;
      opens_q     <= '0;
      gap_cols_q  <= '0;
      ops_q       <= '0;
      cols_q      <= '0;
    end else if (go) begin
      if (col_i.last) begin
        run_kind_q  <= KindSub;
        run_open_q  <= 1'b0;
        run_count_q <= '0;
        score_q     <= '0;
        ident_q     <= '0;
        opens_q     <= '0;
        gap_cols_q  <= '0;
        ops_q       <= '0;
        cols_q      <= '0;
      end else begin
        run_kind_q  <= col_i.kind;
        run_open_q  <= 1'b1;
        run_count_q <= run_count_n;
        score_q     <= score_n;
        ident_q     <= ident_n;
        opens_q     <= opens_n;
        gap_cols_q  <= gap_cols_n;
        ops_q       <= ops_n;
        cols_q      <= cols_n;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && col_i.last) |=> (!run_open_q && cols_q == '0 && score_q == '0))
    else $error("state not cleared after final column");

  a_open_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_open_q |-> (run_count_q != '0 && ops_q != '0))
    else $error("open run without length");

endmodule

>>> rtl/aesu_outq.sv
module aesu_outq import aesu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  input  res_t      res_a_i,
  input  res_t      res_b_i,
  output logic      room_o,
  input  logic      pop_i,
  output logic      empty_o,
  output res_t      head_o
);

  res_t               mem_q [OutDepth];
  logic [OutPtrW-1:0] wp_q, rp_q, wp_b;
  logic [OutCntW-1:0] cnt_q, npush;
  logic               do_pop;

  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rp_q];

  // a column may write two words, so keep two slots spare
  assign room_o = (cnt_q <= OutCntW'(OutDepth - 2));

  assign npush = OutCntW'(push_i.a_valid) + OutCntW'(push_i.b_valid);
  assign wp_b  = push_i.a_valid ? wp_q + OutPtrW'(1) : wp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + OutPtrW'(npush);
      cnt_q <= cnt_q + npush - OutCntW'(do_pop);
      if (do_pop) begin
        rp_q <= rp_q + OutPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.a_valid) begin
      mem_q[wp_q] <= res_a_i;
    end
    if (push_i.b_valid) begin
      mem_q[wp_b] <= res_b_i;
    end
  end

  a_out_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OutCntW'(OutDepth))
    else $error("result queue overflow");

endmodule

>>> rtl/alignment_edit_script_scorer_unit.sv
// path: a word reaches the result ports after the column that closes its run is accepted,
//   through a column queue write, then a result queue write
// throughput: one column per cycle while results drain one word per cycle;
//   a column that closes a run and ends the alignment writes two words
// reset: asynchronous, active low; clears queues and run state, loads the
//   register defaults; payload storage is not reset
module alignment_edit_script_scorer_unit import aesu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // column input
  input  logic                push,
  output logic                full,
  input  logic [7:0]          query_char_i,
  input  logic [7:0]          subject_char_i,
  input  logic                end_of_alignment_i,
  // result output
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          op_kind_o,
  output logic [16:0]         run_length_o,
  output logic                is_final_o,
  output logic signed [31:0]  total_score_o,
  output logic [16:0]         identity_count_o,
  output logic [16:0]         gap_open_count_o,
  output logic [16:0]         gap_base_count_o,
  output logic [16:0]         op_count_o,
  output logic [16:0]         align_length_o,
  // register write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]          cfg_wdata_i
);

  cfg_t      cfg_q;
  logic      col_valid, col_pop, room;
  col_t      col;
  res_push_t res_push;
  res_t      res_a, res_b, head;

  // register file; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_reward     <= 8'd1;
      cfg_q.mismatch_penalty <= 8'd2;
      cfg_q.gap_open_cost    <= 8'd0;
      cfg_q.gap_extend_cost  <= 8'd2;
      cfg_q.gap_symbol       <= 8'd45;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegMatchReward:     cfg_q.match_reward     <= cfg_wdata_i;
        RegMismatchPenalty: cfg_q.mismatch_penalty <= cfg_wdata_i;
        RegGapOpenCost:     cfg_q.gap_open_cost    <= cfg_wdata_i;
        RegGapExtendCost:   cfg_q.gap_extend_cost  <= cfg_wdata_i;
        RegGapSymbol:       cfg_q.gap_symbol       <= cfg_wdata_i;
        default:            ;
      endcase
    end
  end

  // front: gap detection and run kind resolution, then the column queue
  aesu_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (push),
    .query_char_i       (query_char_i),
    .subject_char_i     (subject_char_i),
    .end_of_alignment_i (end_of_alignment_i),
    .gap_symbol_i       (cfg_q.gap_symbol),
    .full_o             (full),
    .col_valid_o        (col_valid),
    .col_o              (col),
    .col_pop_i          (col_pop)
  );

  // back: run tracking, counters and saturating score
  aesu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .col_valid_i (col_valid),
    .col_i       (col),
    .room_i      (room),
    .col_pop_o   (col_pop),
    .push_o      (res_push),
    .res_a_o     (res_a),
    .res_b_o     (res_b)
  );

  // result queue, up to two words written per cycle
  aesu_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_a_i (res_a),
    .res_b_i (res_b),
    .room_o  (room),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  assign op_kind_o        = head.kind;
  assign run_length_o     = head.run_length;
  assign is_final_o       = head.is_final;
  assign total_score_o    = head.score;
  assign identity_count_o = head.ident;
  assign gap_open_count_o = head.opens;
  assign gap_base_count_o = head.gap_cols;
  assign op_count_o       = head.ops;
  assign align_length_o   = head.cols;

endmodule

>>> test/alignment_edit_script_scorer_unit_tb.sv
module alignment_edit_script_scorer_unit_tb;
  import aesu_pkg::*;

  // clocking and run length
  localparam int unsigned ClkHalf     = 6;
  localparam int unsigned ResetCycles = 5;
  localparam int unsigned DrainCycles = 8;       // margin after the last predicted word
  localparam int unsigned LimitCycles = 600000;  // far above the slowest correct run
  localparam int unsigned PhaseCols   = 190;     // least number of random columns per register setting
  localparam int unsigned NumPhases   = 10;

  // register index space beyond the last defined register
  localparam logic [CfgIdxW-1:0] RegTopIdx = '1;

  // score ceiling and floor of a signed 32-bit accumulator
  localparam longint ScoreMax = 64'sd2147483647;
  localparam longint ScoreMin = -ScoreMax - 64'sd1;

  // stall modes of the result side
  typedef enum logic [1:0] {
    RxFree,
    RxSparse,
    RxRandom,
    RxSlow
  } rx_mode_e;

  // tracks the edit script and running totals of the alignment in flight
  class edit_op_tracker;
    cfg_t   cfg;
    kind_e  run_kind;
    bit     run_open;
    cnt_t   run_cnt;
    longint score;
    cnt_t   ident;
    cnt_t   opens;
    cnt_t   gap_cols;
    cnt_t   ops;
    cnt_t   cols;
    res_t   pending_ops[$];
    int     errors;
    int     words_seen;

    function new();
      cfg.match_reward     = 8'd1;
      cfg.mismatch_penalty = 8'd2;
      cfg.gap_open_cost    = 8'd0;
      cfg.gap_extend_cost  = 8'd2;
      cfg.gap_symbol       = 8'd45;
      errors     = 0;
      words_seen = 0;
      clear_totals();
    endfunction

    function void clear_totals();
      run_kind = KindSub;
      run_open = 1'b0;
      run_cnt  = '0;
      score    = 0;
      ident    = '0;
      opens    = '0;
      gap_cols = '0;
      ops      = '0;
      cols     = '0;
    endfunction

    // counters stop at the alignment length ceiling
    function cnt_t cap_add(cnt_t v, cnt_t by);
      int unsigned s;
      s = int'(v) + int'(by);
      return (s > CntCap) ? CntCapV : cnt_t'(s);
    endfunction

    function void add_score(longint delta);
      score = score + delta;
      if (score > ScoreMax) score = ScoreMax;
      if (score < ScoreMin) score = ScoreMin;
    endfunction

    // gap runs are charged open plus extend times length when they close
    function void close_run(bit is_last);
      res_t w;
      if (run_kind != KindSub) begin
        add_score(-(longint'(cfg.gap_open_cost) +
                    longint'(cfg.gap_extend_cost) * longint'(run_cnt)));
        opens    = cap_add(opens, cnt_t'(1));
        gap_cols = cap_add(gap_cols, run_cnt);
      end
      ops          = cap_add(ops, cnt_t'(1));
      w.kind       = run_kind;
      w.run_length = run_cnt;
      w.is_final   = is_last;
      w.score      = score[31:0];
      w.ident      = ident;
      w.opens      = opens;
      w.gap_cols   = gap_cols;
      w.ops        = ops;
      w.cols       = cols;
      pending_ops.push_back(w);
      run_open = 1'b0;
    endfunction

    function void note_column(logic [7:0] q, logic [7:0] s, logic is_last);
      bit    q_gap;
      bit    s_gap;
      kind_e kind;
      q_gap = (q == cfg.gap_symbol);
      s_gap = (s == cfg.gap_symbol);
      if (!q_gap && !s_gap) kind = KindSub;
      else if (q_gap && s_gap) kind = (run_open && run_kind != KindSub) ? run_kind : KindDel;
      else if (q_gap) kind = KindDel;
      else kind = KindIns;
      // a kind change closes the previous run before this column counts
      if (run_open && kind != run_kind) close_run(1'b0);
      if (!run_open) begin
        run_open = 1'b1;
        run_kind = kind;
        run_cnt  = '0;
      end
      run_cnt = cap_add(run_cnt, cnt_t'(1));
      cols    = cap_add(cols, cnt_t'(1));
      if (kind == KindSub) begin
        if (q == s) begin
          ident = cap_add(ident, cnt_t'(1));
          add_score(longint'(cfg.match_reward));
        end else begin
          add_score(-longint'(cfg.mismatch_penalty));
        end
      end
      if (is_last) begin
        close_run(1'b1);
        clear_totals();
      end
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [7:0] v);
      case (idx)
        RegMatchReward:     cfg.match_reward     = v;
        RegMismatchPenalty: cfg.mismatch_penalty = v;
        RegGapOpenCost:     cfg.gap_open_cost    = v;
        RegGapExtendCost:   cfg.gap_extend_cost  = v;
        RegGapSymbol:       cfg.gap_symbol       = v;
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("%s", msg);
      errors++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("word %0d %s: got %0d, expected %0d",
                         words_seen, name, $signed(got), $signed(want)));
    endtask

    task check_op(res_t got);
      res_t want;
      words_seen++;
      if (pending_ops.size() == 0) begin
        report($sformatf("word %0d: result with nothing outstanding", words_seen));
        return;
      end
      want = pending_ops.pop_front();
      check_field("op_kind",        got.kind,       want.kind);
      check_field("run_length",     got.run_length, want.run_length);
      check_field("is_final",       got.is_final,   want.is_final);
      check_field("total_score",    got.score,      want.score);
      check_field("identity_count", got.ident,      want.ident);
      check_field("gap_open_count", got.opens,      want.opens);
      check_field("gap_base_count", got.gap_cols,   want.gap_cols);
      check_field("op_count",       got.ops,        want.ops);
      check_field("align_length",   got.cols,       want.cols);
    endtask
  endclass

  // dut ports, all inputs known from time zero
  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                push               = 1'b0;
  logic                full;
  logic [7:0]          query_char_i       = '0;
  logic [7:0]          subject_char_i     = '0;
  logic                end_of_alignment_i = 1'b0;
  logic                empty;
  logic                pop                = 1'b0;
  logic [1:0]          op_kind_o;
  logic [16:0]         run_length_o;
  logic                is_final_o;
  logic signed [31:0]  total_score_o;
  logic [16:0]         identity_count_o;
  logic [16:0]         gap_open_count_o;
  logic [16:0]         gap_base_count_o;
  logic [16:0]         op_count_o;
  logic [16:0]         align_length_o;
  logic                cfg_we_i           = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i        = '0;
  logic [7:0]          cfg_wdata_i        = '0;

  edit_op_tracker tracker = new();

  // gap code the stimulus currently builds its columns around
  logic [7:0]  gap_sym    = 8'd45;
  int unsigned burst_left = 0;
  int unsigned cols_sent  = 0;
  int unsigned rx_cycle   = 0;

  alignment_edit_script_scorer_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .query_char_i       (query_char_i),
    .subject_char_i     (subject_char_i),
    .end_of_alignment_i (end_of_alignment_i),
    .empty              (empty),
    .pop                (pop),
    .op_kind_o          (op_kind_o),
    .run_length_o       (run_length_o),
    .is_final_o         (is_final_o),
    .total_score_o      (total_score_o),
    .identity_count_o   (identity_count_o),
    .gap_open_count_o   (gap_open_count_o),
    .gap_base_count_o   (gap_base_count_o),
    .op_count_o         (op_count_o),
    .align_length_o     (align_length_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #(LimitCycles * 2 * ClkHalf);
    $display("RESULT: ERROR");
    $finish;
  end

  // input side monitor: every accepted column goes to the predictor
  always @(posedge clk_i) begin
    if (rst_ni && push && !full)
      tracker.note_column(query_char_i, subject_char_i, end_of_alignment_i);
  end

  // output side monitor: every accepted word is checked against the oldest prediction
  always @(posedge clk_i) begin : mon_out
    res_t got;
    if (rst_ni && pop && !empty) begin
      got.kind       = kind_e'(op_kind_o);
      got.run_length = run_length_o;
      got.is_final   = is_final_o;
      got.score      = total_score_o;
      got.ident      = identity_count_o;
      got.opens      = gap_open_count_o;
      got.gap_cols   = gap_base_count_o;
      got.ops        = op_count_o;
      got.cols       = align_length_o;
      tracker.check_op(got);
    end
  end

  // receiver stall pattern: the mode steps through free, sparse, random and slow popping
  always @(posedge clk_i) begin : rx_stall
    rx_mode_e mode;
    mode = rx_mode_e'(rx_cycle >> 7);
    rx_cycle <= rx_cycle + 1;
    case (mode)
      RxFree:   pop <= 1'b1;
      RxSparse: pop <= (rx_cycle % 4) != 0;
      RxRandom: pop <= 1'($urandom_range(1));
      default:  pop <= (rx_cycle % 7) == 0;
    endcase
  end

  // hold one column on the input until the block takes it
  task automatic send_col(logic [7:0] q, logic [7:0] s, logic is_last);
    push               <= 1'b1;
    query_char_i       <= q;
    subject_char_i     <= s;
    end_of_alignment_i <= is_last;
    do @(posedge clk_i); while (full !== 1'b0);
    cols_sent++;
  endtask

  // column inside a burst; a random gap, sometimes none, follows when the burst runs out
  task automatic pace_col(logic [7:0] q, logic [7:0] s, logic is_last);
    int unsigned gap;
    send_col(q, s, is_last);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 1);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(40, 1);
    end
  endtask

  // any code except the current gap code
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom);
    if (c == gap_sym) c = c ^ 8'h01;
    return c;
  endfunction

  // well-formed alignment: a few runs of random kind and length, usually ended
  task automatic send_alignment();
    int unsigned runs;
    int unsigned len;
    kind_e       kind;
    logic [7:0]  q;
    logic [7:0]  s;
    logic        is_last;
    bit          drop_end;
    runs     = $urandom_range(6, 1);
    drop_end = ($urandom_range(9) == 0);  // broken alignment runs into the next one
    for (int r = 0; r < runs; r++) begin
      kind = kind_e'($urandom_range(2));
      len  = ($urandom_range(9) == 0) ? $urandom_range(24, 1) : $urandom_range(5, 1);
      for (int i = 0; i < len; i++) begin
        case (kind)
          KindSub: begin
            q = plain_char();
            s = ($urandom_range(3) != 0) ? q : plain_char();
          end
          KindDel: begin
            q = gap_sym;
            s = ($urandom_range(4) == 0) ? gap_sym : plain_char();
          end
          default: begin
            s = gap_sym;
            q = ($urandom_range(4) == 0) ? gap_sym : plain_char();
          end
        endcase
        is_last = !drop_end && (r == runs - 1) && (i == len - 1);
        pace_col(q, s, is_last);
      end
    end
  endtask

  // fully random column, end mark now and then
  task automatic send_noise();
    pace_col(8'($urandom), 8'($urandom), $urandom_range(7) == 0);
  endtask

  // stop pushing and wait until every predicted word has come out, then let the pipe empty
  task automatic settle();
    push       <= 1'b0;
    burst_left =  0;
    do @(posedge clk_i); while (tracker.pending_ops.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    tracker.set_reg(idx, v);
  endtask

  // all five registers back to back, plus one write to an undefined index
  task automatic load_config(cfg_t c);
    write_reg(RegMatchReward,     c.match_reward);
    write_reg(RegMismatchPenalty, c.mismatch_penalty);
    write_reg(RegGapOpenCost,     c.gap_open_cost);
    write_reg(RegGapExtendCost,   c.gap_extend_cost);
    write_reg(RegGapSymbol,       c.gap_symbol);
    write_reg(CfgIdxW'($urandom_range(RegTopIdx, RegGapSymbol + 1)), 8'($urandom));
    cfg_we_i <= 1'b0;
    gap_sym  =  c.gap_symbol;
  endtask

  initial begin : stim
    cfg_t        c;
    int unsigned phase_end;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed columns on the reset register values (gap code 45)
    pace_col(8'h00,   8'h00,   1'b0);  // match at the low code
    pace_col(8'hff,   8'hff,   1'b0);  // match at the high code
    pace_col(8'h00,   8'hff,   1'b0);  // mismatch
    pace_col(8'hff,   8'h00,   1'b0);  // mismatch
    pace_col(gap_sym, 8'h47,   1'b0);  // deletion closes the substitution run
    pace_col(gap_sym, gap_sym, 1'b0);  // both rows gap extend the deletion
    pace_col(8'h54,   gap_sym, 1'b0);  // insertion closes the deletion
    pace_col(gap_sym, gap_sym, 1'b0);  // both rows gap extend the insertion
    pace_col(gap_sym, gap_sym, 1'b0);
    pace_col(8'h41,   8'h43,   1'b1);  // kind change and end together: two words
    pace_col(gap_sym, gap_sym, 1'b0);  // both rows gap with no run open: deletion
    pace_col(gap_sym, gap_sym, 1'b1);
    pace_col(8'h41,   8'h41,   1'b1);  // single column alignment
    pace_col(8'h43,   8'h43,   1'b0);
    pace_col(gap_sym, gap_sym, 1'b0);  // both rows gap after a substitution: deletion
    pace_col(gap_sym, 8'h41,   1'b1);
    pace_col(8'h41,   gap_sym, 1'b1);  // single column insertion
    settle();

    // random phases, each on its own register setting
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: c = '0;  // all costs zero, gap code at the low extreme
        1: c = '1;  // all costs at maximum, gap code at the high extreme
        2: begin    // reset values, written explicitly
          c.match_reward     = 8'd1;
          c.mismatch_penalty = 8'd2;
          c.gap_open_cost    = 8'd0;
          c.gap_extend_cost  = 8'd2;
          c.gap_symbol       = 8'd45;
        end
        default: begin
          c.match_reward     = 8'($urandom);
          c.mismatch_penalty = 8'($urandom);
          c.gap_open_cost    = 8'($urandom);
          c.gap_extend_cost  = 8'($urandom);
          c.gap_symbol       = 8'($urandom);
        end
      endcase
      load_config(c);
      // mostly well-formed alignments, about one pick in eight a single noise column
      phase_end = cols_sent + PhaseCols;
      while (cols_sent < phase_end) begin
        if ($urandom_range(7) == 0) send_noise();
        else send_alignment();
      end
      settle();
    end

    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
